// ===== hdl/acs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package acs_pkg;

  // Sample width used when the top level is not told otherwise.
  localparam int SAMPLE_WIDTH_DEFAULT = 16;

  // Register field widths.
  localparam int TICK_WIDTH     = 16;
  localparam int FACTOR_WIDTH   = 15;
  localparam int FRACTION_WIDTH = 16;
  localparam int CFG_DATA_WIDTH = 16;
  localparam int CFG_IDX_WIDTH  = 2;

  // Register indexes.
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DECAY_PERIOD = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DECAY_FACTOR = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_THRESH_FRAC  = 2'd2;

  // Register values after reset.
  localparam logic [TICK_WIDTH-1:0]     DECAY_PERIOD_RESET = 16'd24000;
  localparam logic [FACTOR_WIDTH-1:0]   DECAY_FACTOR_RESET = 15'd29491;
  localparam logic [FRACTION_WIDTH-1:0] THRESH_FRAC_RESET  = 16'd3277;

  // Sliced symbol codes.
  localparam logic [1:0] LEVEL_POS  = 2'b01;
  localparam logic [1:0] LEVEL_ZERO = 2'b00;
  localparam logic [1:0] LEVEL_NEG  = 2'b11;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Head-of-queue status handed from the front part to the back part.
  typedef struct packed {
    logic valid;
    logic decay;
  } acs_qctl_t;

endpackage

`default_nettype wire

// ===== hdl/acs_sample_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one audio sample per beat.
interface acs_sample_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

// ===== hdl/acs_level_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Output channel: one sliced symbol per beat.
interface acs_level_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] level;

  modport source (output valid, output level, input ready);
  modport sink   (input valid, input level, output ready);
endinterface

`default_nettype wire

// ===== hdl/acs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acs_front
  import acs_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [TICK_WIDTH-1:0]          decay_period,
  acs_sample_if.sink                          samples,
  output      acs_qctl_t                      q_ctl,
  output      logic signed [SAMPLE_WIDTH-1:0] q_sample,
  input  wire logic                           q_pop
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

  logic [TICK_WIDTH-1:0]          tick_count;
  logic [TICK_WIDTH-1:0]          tick_base;
  logic [TICK_WIDTH-1:0]          tick_count_next;
  logic                           decay_now;
  logic signed [SAMPLE_WIDTH-1:0] mem_sample [QUEUE_DEPTH];
  logic                           mem_decay  [QUEUE_DEPTH];
  logic [PTR_W-1:0]               wr_ptr;
  logic [PTR_W-1:0]               rd_ptr;
  logic [CNT_W-1:0]               fill;
  logic                           push;
  logic                           pop;

  assign samples.ready = (fill != CNT_W'(QUEUE_DEPTH));
  assign push          = samples.valid && samples.ready;
  assign pop           = q_pop && (fill != '0);

  // Classify the sample: a decay is due once the count has reached the period.
  always_comb begin
    decay_now       = (tick_count >= decay_period);
    tick_base       = decay_now ? '0 : tick_count;
    tick_count_next = (tick_base != TICK_MAX) ? tick_base + 1'b1 : tick_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (push) begin
      tick_count <= tick_count_next;
    end
  end

  // Small queue towards the back part.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_sample[wr_ptr] <= samples.sample;
      mem_decay[wr_ptr]  <= decay_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  assign q_ctl.valid = (fill != '0);
  assign q_ctl.decay = mem_decay[rd_ptr];
  assign q_sample    = mem_sample[rd_ptr];

endmodule

`default_nettype wire

// ===== hdl/acs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acs_back
  import acs_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [FACTOR_WIDTH-1:0]        decay_factor,
  input  wire logic [FRACTION_WIDTH-1:0]      threshold_fraction,
  input  wire acs_qctl_t                      q_ctl,
  input  wire logic signed [SAMPLE_WIDTH-1:0] q_sample,
  output      logic                           q_pop,
  acs_level_if.source                         levels
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int DPW  = SW + FACTOR_WIDTH;
  localparam int OPW  = SW + FRACTION_WIDTH;
  localparam int CW   = SW + 3;

  localparam logic S_DECAY = 1'b0;
  localparam logic S_WIDEN = 1'b1;

  // Scale an extreme towards zero by a Q0.15 factor, truncating the magnitude.
  function automatic logic signed [SW-1:0] decay_one(
    input logic signed [SW-1:0]     x,
    input logic [FACTOR_WIDTH-1:0]  f
  );
    logic [SW-1:0]  mag;
    logic [DPW-1:0] prod;
    logic [SW-1:0]  scaled;
    mag    = x[SW-1] ? SW'(-x) : SW'(x);
    prod   = DPW'(mag) * DPW'(f);
    scaled = prod[DPW-1:FACTOR_WIDTH];
    return x[SW-1] ? -$signed(scaled) : $signed(scaled);
  endfunction

  logic                    state;
  logic signed [SW-1:0]    peak_high;
  logic signed [SW-1:0]    peak_low;
  logic signed [SW-1:0]    cur_sample;
  logic signed [SW-1:0]    dec_high;
  logic signed [SW-1:0]    dec_low;
  logic signed [SW-1:0]    new_high;
  logic signed [SW-1:0]    new_low;
  logic signed [SW:0]      diff;
  logic [SW-1:0]           spread;
  logic [OPW-1:0]          off_prod;
  logic                    pend_valid;
  logic signed [SW-1:0]    pend_sample;
  logic signed [SW:0]      pend_sum;
  logic [SW-1:0]           pend_off;
  logic                    pend_free;
  logic                    out_load;
  logic                    widen_done;
  logic signed [CW-1:0]    s2;
  logic signed [CW-1:0]    upper;
  logic signed [CW-1:0]    lower;
  logic [1:0]              level_next;
  logic                    out_valid;
  logic [1:0]              out_level;

  assign out_load   = pend_valid && (!out_valid || levels.ready);
  assign pend_free  = !pend_valid || out_load;
  assign q_pop      = (state == S_DECAY) && q_ctl.valid;
  assign widen_done = (state == S_WIDEN) && pend_free;

  // Sequencer: decay step, then widen and offset step.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_DECAY;
    end else begin
      unique case (state)
        S_DECAY: if (q_ctl.valid) state <= S_WIDEN;
        S_WIDEN: if (pend_free)   state <= S_DECAY;
        default: state <= S_DECAY;
      endcase
    end
  end

  // Decay step: scale the stored extremes when the front flagged a decay.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_sample <= q_sample;
      dec_high   <= q_ctl.decay ? decay_one(peak_high, decay_factor) : peak_high;
      dec_low    <= q_ctl.decay ? decay_one(peak_low, decay_factor) : peak_low;
    end
  end

  // Widen step: include the sample and form the threshold offset.
  always_comb begin
    new_high = (cur_sample > dec_high) ? cur_sample : dec_high;
    new_low  = (cur_sample < dec_low) ? cur_sample : dec_low;
    diff     = (SW + 1)'(new_high) - (SW + 1)'(new_low);
    spread   = diff[SW-1:0];
    off_prod = OPW'(spread) * OPW'(threshold_fraction);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_high <= '0;
      peak_low  <= '0;
    end else if (widen_done) begin
      peak_high <= new_high;
      peak_low  <= new_low;
    end
  end

  always_ff @(posedge clk) begin
    if (widen_done) begin
      pend_sample <= cur_sample;
      pend_sum    <= (SW + 1)'(new_high) + (SW + 1)'(new_low);
      pend_off    <= off_prod[OPW-1:FRACTION_WIDTH];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (widen_done) begin
      pend_valid <= 1'b1;
    end else if (out_load) begin
      pend_valid <= 1'b0;
    end
  end

  // Slice at doubled scale so the centre is exact.
  always_comb begin
    s2    = CW'(pend_sample) <<< 1;
    upper = CW'(pend_sum) + $signed(CW'({pend_off, 1'b0}));
    lower = CW'(pend_sum) - $signed(CW'({pend_off, 1'b0}));
    if (s2 >= upper) begin
      level_next = LEVEL_POS;
    end else if (s2 <= lower) begin
      level_next = LEVEL_NEG;
    end else begin
      level_next = LEVEL_ZERO;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (levels.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_level <= level_next;
    end
  end

  assign levels.valid = out_valid;
  assign levels.level = out_level;

endmodule

`default_nettype wire

// ===== hdl/adaptive_three_level_slicer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Adaptive three-level slicer. Each sample beat on samples yields exactly one
// beat on levels: +1 (01) when twice the sample is at or above the sum of the
// tracked extremes plus twice the offset, -1 (11) when at or below the sum
// minus twice the offset, 0 otherwise. The extremes decay by decay_factor once
// decay_period samples have been counted. The back part takes one sample at
// a time: a decay multiply step, then a step widening the extremes with the
// offset multiply, as the next sample needs the updated extremes. A level
// passes from the queue through the decay, pending and output registers;
// earlier samples and output stalls hold it back. A two-entry queue lets the
// input keep accepting while a result waits on a stalled output. The user
// writes configuration through cfg_we, cfg_index and cfg_data only while the
// block is idle; the block does not enforce it. Unknown indexes are ignored.

module adaptive_three_level_slicer
  import acs_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_data,
  acs_sample_if.sink                     samples,
  acs_level_if.source                    levels
);

  logic [TICK_WIDTH-1:0]          decay_period;
  logic [FACTOR_WIDTH-1:0]        decay_factor;
  logic [FRACTION_WIDTH-1:0]      threshold_fraction;
  acs_qctl_t                      q_ctl;
  logic signed [SAMPLE_WIDTH-1:0] q_sample;
  logic                           q_pop;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      decay_period       <= DECAY_PERIOD_RESET;
      decay_factor       <= DECAY_FACTOR_RESET;
      threshold_fraction <= THRESH_FRAC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DECAY_PERIOD: decay_period       <= cfg_data[TICK_WIDTH-1:0];
        CFG_DECAY_FACTOR: decay_factor       <= cfg_data[FACTOR_WIDTH-1:0];
        CFG_THRESH_FRAC:  threshold_fraction <= cfg_data[FRACTION_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  acs_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .decay_period (decay_period),
    .samples      (samples),
    .q_ctl        (q_ctl),
    .q_sample     (q_sample),
    .q_pop        (q_pop)
  );

  acs_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk                (clk),
    .rst                (rst),
    .decay_factor       (decay_factor),
    .threshold_fraction (threshold_fraction),
    .q_ctl              (q_ctl),
    .q_sample           (q_sample),
    .q_pop              (q_pop),
    .levels             (levels)
  );

endmodule

`default_nettype wire

// ===== hdl/acs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acs_checker
  import acs_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input wire logic                    clk,
  input wire logic                    rst,
  input wire logic                    in_valid,
  input wire logic                    in_ready,
  input wire logic [SAMPLE_WIDTH-1:0] in_sample,
  input wire logic                    out_valid,
  input wire logic                    out_ready,
  input wire logic [1:0]              out_level
);

  // Samples accepted whose level has not yet been taken; at most five fit.
  logic [2:0] outstanding;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid && in_ready;
  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      outstanding <= '0;
    end else if (in_beat && !out_beat) begin
      outstanding <= outstanding + 1'b1;
    end else if (out_beat && !in_beat) begin
      outstanding <= outstanding - 1'b1;
    end
  end

  // A level is never shown without a sample behind it.
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (outstanding != 3'd0))
    else $error("level beat without an outstanding sample");

  // Input is held off before the pipeline overfills.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (outstanding != 3'd6) && (outstanding != 3'd7))
    else $error("more samples in flight than the block can hold");

  // Only the three legal symbol codes appear.
  a_level_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_level == LEVEL_POS || out_level == LEVEL_ZERO ||
                   out_level == LEVEL_NEG))
    else $error("illegal level code");

  // A stalled level beat holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_level)))
    else $error("stalled level beat changed");

  // Out of reset the block is empty and ready for samples.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("block not empty after reset");

  logic unused_sample;
  assign unused_sample = ^in_sample;

endmodule

bind adaptive_three_level_slicer acs_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_acs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .in_sample (samples.sample),
  .out_valid (levels.valid),
  .out_ready (levels.ready),
  .out_level (levels.level)
);

`default_nettype wire
